// ----- hw/rtl/skac_pkg.sv -----
// Shared types, register indexes and constants of the soft-knee compressor.
package skac_pkg;

  // Field widths.
  localparam int unsigned SampleW   = 16;
  localparam int unsigned GainW     = 10;
  localparam int unsigned LevelW    = 15;
  localparam int unsigned RatioW    = 17;
  localparam int unsigned CoeffW    = 32;
  localparam int unsigned VolW      = 7;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned CfgIdxW   = 3;
  // Compressed magnitude in Q16 and its product with the volume.
  localparam int unsigned MagQW     = 46;
  localparam int unsigned ScaledW   = MagQW + VolW;

  // Register indexes on the write port.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PRE_GAIN  = 3'd0,
    CFG_THRESHOLD = 3'd1,
    CFG_KNEE      = 3'd2,
    CFG_RATIO     = 3'd3,
    CFG_COEFF     = 3'd4,
    CFG_VOLUME    = 3'd5
  } cfg_idx_e;

  // Reset values of the registers.
  localparam logic [GainW-1:0]  PreGainRst   = 10'd256;
  localparam logic [LevelW-1:0] ThresholdRst = 15'd16384;
  localparam logic [LevelW-1:0] KneeRst      = 15'd2048;
  localparam logic [RatioW-1:0] RatioRst     = 17'd16384;
  localparam logic [CoeffW-1:0] CoeffRst     = 32'd262144;
  localparam logic [VolW-1:0]   VolumeRst    = 7'd50;

  // Volume saturates at one hundred percent.
  localparam logic [VolW-1:0] VolMax = 7'd100;

  // Clip limits on the scaled value: magnitude times 100 times 2^16.
  localparam logic [ScaledW-1:0] LimPos = 53'd214741811200;
  localparam logic [ScaledW-1:0] LimNeg = 53'd214748364800;

  // floor(x / 100) = (x * RecipHundred) >> RecipShift for x below 2^22.
  localparam int unsigned QuotInW    = 22;
  localparam int unsigned RecipW     = 23;
  localparam int unsigned RecipShift = 29;
  localparam logic [RecipW-1:0] RecipHundred = 23'd5368710;

  // Output magnitudes when the clamp acts.
  localparam logic [SampleW-1:0] MagPosMax = 16'h7FFF;
  localparam logic [SampleW-1:0] MagNegMax = 16'h8000;

  // Compression zone of one sample.
  typedef enum logic [1:0] {
    BR_PASS  = 2'd0,
    BR_KNEE  = 2'd1,
    BR_RATIO = 2'd2
  } branch_e;

  // Register file contents.
  typedef struct packed {
    logic [GainW-1:0]  pre_gain_q8;
    logic [LevelW-1:0] threshold_level;
    logic [LevelW-1:0] knee_width;
    logic [RatioW-1:0] ratio_recip_q16;
    logic [CoeffW-1:0] knee_coeff_q32;
    logic [VolW-1:0]   volume_percent;
  } cfg_t;

  // Handoff from the compression stages to the output scaling stages.
  typedef struct packed {
    logic             valid;
    logic             neg;
    logic             last;
    logic [MagQW-1:0] mag;
  } comp_t;

endpackage

// ----- hw/rtl/skac_cfg_regs.sv -----
// Configuration register file of the soft-knee compressor.
module skac_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [skac_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [skac_pkg::CfgDataW-1:0] cfg_wdata_i,
  output skac_pkg::cfg_t                cfg_o
);
  import skac_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode a write; indexes past the list leave the registers alone.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PRE_GAIN:  cfg_d.pre_gain_q8     = cfg_wdata_i[GainW-1:0];
        CFG_THRESHOLD: cfg_d.threshold_level = cfg_wdata_i[LevelW-1:0];
        CFG_KNEE:      cfg_d.knee_width      = cfg_wdata_i[LevelW-1:0];
        CFG_RATIO:     cfg_d.ratio_recip_q16 = cfg_wdata_i[RatioW-1:0];
        CFG_COEFF:     cfg_d.knee_coeff_q32  = cfg_wdata_i[CoeffW-1:0];
        CFG_VOLUME:    cfg_d.volume_percent  = cfg_wdata_i[VolW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  // Register storage with documented reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pre_gain_q8     <= PreGainRst;
      cfg_q.threshold_level <= ThresholdRst;
      cfg_q.knee_width      <= KneeRst;
      cfg_q.ratio_recip_q16 <= RatioRst;
      cfg_q.knee_coeff_q32  <= CoeffRst;
      cfg_q.volume_percent  <= VolumeRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/skac_gain_comp.sv -----
// Pre-gain and soft-knee compression stages, five register stages deep.
module skac_gain_comp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic signed [skac_pkg::SampleW-1:0] sample_in_i,
  input  logic                                last_in_i,
  input  skac_pkg::cfg_t                      cfg_i,
  output skac_pkg::comp_t                     comp_o
);
  import skac_pkg::*;

  // Stage 1: magnitude of the sample times the pre-gain.
  logic                     neg_in;
  logic [SampleW-1:0]       mag_in;
  logic [SampleW+GainW-1:0] gain_full;
  logic                     v1_q, neg1_q, last1_q;
  logic [16:0]              a1_q;

  assign neg_in    = sample_in_i[SampleW-1];
  assign mag_in    = neg_in ? SampleW'(-sample_in_i) : SampleW'(sample_in_i);
  assign gain_full = mag_in * cfg_i.pre_gain_q8;

  // Stage 2: zone decision and the excess over the zone start.
  logic signed [15:0] knee_lo;
  logic signed [17:0] knee_lo_ext;
  logic signed [17:0] knee_exc;
  logic               gt_thr, gt_lo;
  logic [16:0]        thr_exc;
  branch_e            br_d;
  logic               v2_q, neg2_q, last2_q;
  branch_e            br2_q;
  logic [16:0]        diff2_q;
  logic [14:0]        e2_q;
  logic [14:0]        aq2_q;

  assign knee_lo     = $signed({1'b0, cfg_i.threshold_level}) -
                       $signed({1'b0, cfg_i.knee_width});
  assign knee_lo_ext = {{2{knee_lo[15]}}, knee_lo};
  assign gt_thr      = a1_q > {2'b00, cfg_i.threshold_level};
  assign gt_lo       = $signed({1'b0, a1_q}) > knee_lo_ext;
  assign thr_exc     = a1_q - {2'b00, cfg_i.threshold_level};
  // In the knee zone the excess never exceeds the knee width.
  assign knee_exc    = $signed({1'b0, a1_q}) - knee_lo_ext;

  always_comb begin
    if (gt_thr) begin
      br_d = BR_RATIO;
    end else if (gt_lo) begin
      br_d = BR_KNEE;
    end else begin
      br_d = BR_PASS;
    end
  end

  // Stage 3: ratio product and the squared knee excess.
  logic [33:0] ratio_prod;
  logic [29:0] exc_sq;
  logic        v3_q, neg3_q, last3_q;
  branch_e     br3_q;
  logic [33:0] ratio3_q;
  logic [29:0] sq3_q;
  logic [14:0] aq3_q;

  assign ratio_prod = diff2_q * cfg_i.ratio_recip_q16;
  assign exc_sq     = e2_q * e2_q;

  // Stage 4: knee reduction in Q16 and the ratio-zone magnitude.
  logic [61:0]      knee_full;
  logic [34:0]      ratio_mag;
  logic             v4_q, neg4_q, last4_q;
  branch_e          br4_q;
  logic [MagQW-1:0] red4_q;
  logic [34:0]      rmag4_q;
  logic [14:0]      aq4_q;

  assign knee_full = sq3_q * cfg_i.knee_coeff_q32;
  assign ratio_mag = {4'b0000, cfg_i.threshold_level, 16'h0000} + {1'b0, ratio3_q};

  // Stage 5: select the compressed magnitude; the knee keeps the absolute difference.
  logic [MagQW-1:0] aq_shift;
  logic [MagQW-1:0] knee_mag;
  logic [MagQW-1:0] mag_d;
  logic             v5_q, neg5_q, last5_q;
  logic [MagQW-1:0] mag5_q;

  assign aq_shift = {15'h0000, aq4_q, 16'h0000};
  assign knee_mag = (aq_shift >= red4_q) ? (aq_shift - red4_q) : (red4_q - aq_shift);

  always_comb begin
    case (br4_q)
      BR_RATIO: mag_d = {11'h000, rmag4_q};
      BR_KNEE:  mag_d = knee_mag;
      default:  mag_d = aq_shift;
    endcase
  end

  // Valid bits of the five stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Payload of the five stages; the product never reaches its top bit.
  always_ff @(posedge clk_i) begin
    neg1_q   <= neg_in;
    last1_q  <= last_in_i;
    a1_q     <= gain_full[24:8];

    neg2_q   <= neg1_q;
    last2_q  <= last1_q;
    br2_q    <= br_d;
    diff2_q  <= thr_exc;
    e2_q     <= knee_exc[14:0];
    aq2_q    <= a1_q[14:0];

    neg3_q   <= neg2_q;
    last3_q  <= last2_q;
    br3_q    <= br2_q;
    ratio3_q <= ratio_prod;
    sq3_q    <= exc_sq;
    aq3_q    <= aq2_q;

    neg4_q   <= neg3_q;
    last4_q  <= last3_q;
    br4_q    <= br3_q;
    red4_q   <= knee_full[61:16];
    rmag4_q  <= ratio_mag;
    aq4_q    <= aq3_q;

    neg5_q   <= neg4_q;
    last5_q  <= last4_q;
    mag5_q   <= mag_d;
  end

  assign comp_o.valid = v5_q;
  assign comp_o.neg   = neg5_q;
  assign comp_o.last  = last5_q;
  assign comp_o.mag   = mag5_q;

`ifndef SYNTHESIS
  // The largest magnitude times the largest gain stays below the product's top bit.
  gain_top_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i |-> !gain_full[SampleW+GainW-1])
    else $error("pre-gain product overflows the kept bits");

  // Inside the knee zone the excess fits in the knee width.
  knee_exc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && (br_d == BR_KNEE)) |-> (knee_exc[17:LevelW] == '0))
    else $error("knee excess wider than the knee width");
`endif

endmodule

// ----- hw/rtl/skac_out_scale.sv -----
// Volume scaling, clamp and sign restore, three register stages deep.
module skac_out_scale (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  skac_pkg::comp_t                      comp_i,
  input  logic [skac_pkg::VolW-1:0]            volume_i,
  output logic                                 done_o,
  output logic signed [skac_pkg::SampleW-1:0]  sample_out_o,
  output logic                                 clipped_o,
  output logic                                 last_out_o
);
  import skac_pkg::*;

  // Stage 6: magnitude times the saturated volume.
  logic [VolW-1:0]    vol_sat;
  logic [ScaledW-1:0] scaled;
  logic               v6_q, neg6_q, last6_q;
  logic [ScaledW-1:0] s6_q;

  assign vol_sat = (volume_i > VolMax) ? VolMax : volume_i;
  assign scaled  = comp_i.mag * vol_sat;

  // Stage 7: clip test and division by 100 * 2^16 through a reciprocal.
  logic [ScaledW-1:0]      lim;
  logic                    clip_d;
  logic [QuotInW-1:0]      quot_in;
  logic [QuotInW+RecipW-1:0] recip_prod;
  logic                    v7_q, neg7_q, last7_q, clip7_q;
  logic [SampleW-1:0]      mag7_q;

  assign lim        = neg6_q ? LimNeg : LimPos;
  assign clip_d     = s6_q > lim;
  // Below the limit the value shifted by 16 fits in the quotient input.
  assign quot_in    = clip_d ? '0 : s6_q[QuotInW+15:16];
  assign recip_prod = quot_in * RecipHundred;

  // Stage 8: clamp and sign restore into the output register.
  logic [SampleW-1:0] mag_out;
  logic [SampleW-1:0] res_d;
  logic               done_q, clip_q, last_q;
  logic [SampleW-1:0] sample_q;

  assign mag_out = clip7_q ? (neg7_q ? MagNegMax : MagPosMax) : mag7_q;
  assign res_d   = neg7_q ? SampleW'(-mag_out) : mag_out;

  // Valid bits of the three stages and the output strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q   <= 1'b0;
      v7_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v6_q   <= comp_i.valid;
      v7_q   <= v6_q;
      done_q <= v7_q;
    end
  end

  // Payload of the three stages.
  always_ff @(posedge clk_i) begin
    neg6_q   <= comp_i.neg;
    last6_q  <= comp_i.last;
    s6_q     <= scaled;

    neg7_q   <= neg6_q;
    last7_q  <= last6_q;
    clip7_q  <= clip_d;
    mag7_q   <= recip_prod[QuotInW+RecipW-1:RecipShift];

    sample_q <= res_d;
    clip_q   <= clip7_q;
    last_q   <= last7_q;
  end

  assign done_o       = done_q;
  assign sample_out_o = $signed(sample_q);
  assign clipped_o    = clip_q;
  assign last_out_o   = last_q;

`ifndef SYNTHESIS
  // An unclamped quotient never exceeds the largest negative magnitude.
  quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v7_q && !clip7_q) |-> (mag7_q <= MagNegMax))
    else $error("quotient out of range without clip");

  // A clamped result sits on one of the two full-scale codes.
  clip_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && clip_q) |-> ((sample_q == MagPosMax) || (sample_q == MagNegMax)))
    else $error("clipped result is not full scale");
`endif

endmodule

// ----- hw/rtl/soft_knee_audio_compressor_core.sv -----
// Top level of the soft-knee audio compressor: register file and sample pipeline.
//
//  channel   direction  handshake                transfer when
//  command   in         start_i / busy_o         start_i high and busy_o low at the edge
//  result    out        done_o strobe            every edge that ends a cycle with done_o high
//  config    in         cfg_we_i                 every edge with cfg_we_i high
//
// One sample enters per clock; busy_o stays low because no stage ever waits.
// A sample's result shows on done_o once its transfer has passed eight
// register stages: gain product, zone decision, ratio and square products, knee
// product, zone select, volume product, division by 100, clamp and sign.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
// The receiver cannot stall, so results leave on their strobe and nothing is held.
module soft_knee_audio_compressor_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [skac_pkg::SampleW-1:0]  sample_in_i,
  input  logic                                 last_in_i,
  output logic                                 done_o,
  output logic signed [skac_pkg::SampleW-1:0]  sample_out_o,
  output logic                                 clipped_o,
  output logic                                 last_out_o,
  input  logic                                 cfg_we_i,
  input  logic [skac_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [skac_pkg::CfgDataW-1:0]        cfg_wdata_i
);
  import skac_pkg::*;

  cfg_t  cfg;
  comp_t comp;
  logic  in_xfer;

  // The pipeline takes a sample in every cycle.
  assign busy_o  = 1'b0;
  assign in_xfer = start_i && !busy_o;

  // Register file.
  skac_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Pre-gain and compression.
  skac_gain_comp u_gain_comp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_xfer),
    .sample_in_i (sample_in_i),
    .last_in_i   (last_in_i),
    .cfg_i       (cfg),
    .comp_o      (comp)
  );

  // Volume, clamp and output register.
  skac_out_scale u_out_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .comp_i       (comp),
    .volume_i     (cfg.volume_percent),
    .done_o       (done_o),
    .sample_out_o (sample_out_o),
    .clipped_o    (clipped_o),
    .last_out_o   (last_out_o)
  );

`ifndef SYNTHESIS
  // Every accepted sample produces a result after the pipeline latency.
  lat_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> ##8 done_o)
    else $error("accepted sample produced no result");

  // No result appears without a sample accepted one latency earlier.
  lat_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(in_xfer, 8))
    else $error("result without matching sample");

  // The buffer-end mark travels with its sample.
  last_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (last_out_o == $past(last_in_i, 8)))
    else $error("buffer-end mark lost in pipeline");
`endif

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the soft-knee audio compressor core.
module testbench;
  import skac_pkg::*;

  // Cycles from a sample transfer to its result strobe.
  localparam int unsigned Latency      = 8;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned ReportMax    = 10;
  localparam int unsigned RandomPerSet = 138;
  localparam int unsigned NumPhases    = 10;
  // Denominator of the output scale: 100 percent times 2^16.
  localparam longint unsigned OutScale = 64'd6553600;
  // Indexes past the register file; writes to them must be ignored.
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 3'd7;

  // One processed sample as the result port shows it.
  typedef struct packed {
    logic [SampleW-1:0] smp;
    logic               clip;
    logic               last;
  } pcm_out_t;

  // Opening stimulus row; the expected result is typed in only where known is set.
  typedef struct packed {
    logic [SampleW-1:0] smp;
    logic               last;
    logic               known;
    logic [SampleW-1:0] exp_smp;
    logic               exp_clip;
  } opening_row_t;

  // Directed samples under the reset settings (gain 1.0, threshold 16384,
  // knee 2048, ratio 1/4, volume 50).
  localparam opening_row_t OpeningRows [20] = '{
    '{16'sd0,      1'b0, 1'b1, 16'sd0,      1'b0},
    '{16'sd1000,   1'b0, 1'b1, 16'sd500,    1'b0},
    '{-16'sd1000,  1'b1, 1'b1, -16'sd500,   1'b0},
    '{16'sd32767,  1'b0, 1'b1, 16'sd10239,  1'b0},
    '{-16'sd32768, 1'b1, 1'b1, -16'sd10240, 1'b0},
    '{16'sd16384,  1'b0, 1'b1, 16'sd8064,   1'b0},
    '{16'sd15360,  1'b0, 1'b1, 16'sd7648,   1'b0},
    '{-16'sd16384, 1'b0, 1'b1, -16'sd8064,  1'b0},
    '{16'sd1,      1'b0, 1'b1, 16'sd0,      1'b0},
    '{-16'sd1,     1'b1, 1'b1, 16'sd0,      1'b0},
    '{16'sd14336,  1'b0, 1'b0, 16'sd0,      1'b0},
    '{16'sd14337,  1'b1, 1'b0, 16'sd0,      1'b0},
    '{-16'sd14337, 1'b0, 1'b0, 16'sd0,      1'b0},
    '{16'sd16385,  1'b0, 1'b0, 16'sd0,      1'b0},
    '{-16'sd16385, 1'b1, 1'b0, 16'sd0,      1'b0},
    '{16'sd16383,  1'b0, 1'b0, 16'sd0,      1'b0},
    '{16'h5555,    1'b0, 1'b0, 16'sd0,      1'b0},
    '{16'hAAAA,    1'b1, 1'b0, 16'sd0,      1'b0},
    '{16'sd20000,  1'b1, 1'b0, 16'sd0,      1'b0},
    '{-16'sd30000, 1'b0, 1'b0, 16'sd0,      1'b0}
  };

  // Samples at the ends of the input range, sent at the start of every phase.
  localparam logic [SampleW-1:0] EdgeSamples [7] = '{
    16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8001, 16'h7FFE
  };

  // Fixed register settings: gain, threshold, knee, ratio, knee coefficient, volume.
  localparam cfg_t FixedSettings [6] = '{
    '{10'd1023, 15'd32767, 15'd0,     17'd65536,  32'd0,          7'd100},
    '{10'd0,    15'd1,     15'd32767, 17'd0,      32'hFFFFFFFF,   7'd127},
    '{10'd512,  15'd0,     15'd100,   17'd16384,  32'd1000,       7'd100},
    '{10'd300,  15'd8000,  15'd32767, 17'd32768,  32'd50000,      7'd77},
    '{10'd256,  15'd12000, 15'd4000,  17'd8192,   32'd67109,      7'd100},
    '{10'd700,  15'd20000, 15'd1000,  17'd131071, 32'd123456789,  7'd0}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  logic [SampleW-1:0]  sample_in_i = '0;
  logic                last_in_i = 1'b0;
  logic                done_o;
  logic [SampleW-1:0]  sample_out_o;
  logic                clipped_o;
  logic                last_out_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = CFG_PRE_GAIN;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  // Register settings as the block holds them, updated on every write transfer.
  cfg_t        regs_shadow;
  // Results of accepted samples, oldest first.
  pcm_out_t    awaited_outputs[$];
  // Result of the sample now on the command port.
  pcm_out_t    next_expected;
  int unsigned fail_count = 0;

  soft_knee_audio_compressor_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .sample_in_i (sample_in_i),
    .last_in_i   (last_in_i),
    .done_o      (done_o),
    .sample_out_o(sample_out_o),
    .clipped_o   (clipped_o),
    .last_out_o  (last_out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Gain, three-zone compression, volume and clamp of one sample, all magnitudes unsigned.
  function automatic pcm_out_t compress_sample(input logic [SampleW-1:0] smp,
                                               input logic lst);
    pcm_out_t        res;
    logic            neg;
    longint unsigned mag_in, lvl, gained, comp, excess, knee_cut, gained_q;
    longint unsigned vol, scaled, lim, mag_out;
    longint          knee_lo;
    neg     = smp[SampleW-1];
    mag_in  = neg ? 64'd65536 - 64'(smp) : 64'(smp);
    gained  = (mag_in * 64'(regs_shadow.pre_gain_q8)) >> 8;
    lvl     = 64'(regs_shadow.threshold_level);
    knee_lo = longint'(regs_shadow.threshold_level) - longint'(regs_shadow.knee_width);
    if (gained > lvl) begin
      comp = (lvl << 16) + (gained - lvl) * 64'(regs_shadow.ratio_recip_q16);
    end else if (longint'(gained) > knee_lo) begin
      // The knee cut may exceed the magnitude; the distance between them is kept.
      excess   = longint'(gained) - knee_lo;
      knee_cut = (excess * excess * 64'(regs_shadow.knee_coeff_q32)) >> 16;
      gained_q = gained << 16;
      comp     = (gained_q >= knee_cut) ? gained_q - knee_cut : knee_cut - gained_q;
    end else begin
      comp = gained << 16;
    end
    vol      = (regs_shadow.volume_percent > VolMax) ? 64'(VolMax)
                                                      : 64'(regs_shadow.volume_percent);
    scaled   = comp * vol;
    lim      = (neg ? 64'd32768 : 64'd32767) * OutScale;
    res.clip = (scaled > lim);
    if (res.clip) begin
      mag_out = neg ? 64'd32768 : 64'd32767;
    end else begin
      mag_out = scaled / OutScale;
    end
    res.smp  = neg ? 16'(64'd65536 - mag_out) : 16'(mag_out);
    res.last = lst;
    return res;
  endfunction

  // Random sample, in under half of the draws aimed at the threshold or the knee in input terms.
  function automatic logic [SampleW-1:0] pick_sample();
    int unsigned mode;
    longint      target;
    longint      mag;
    logic        neg;
    mode = $urandom_range(99);
    if (mode < 30) begin
      return 16'($urandom());
    end
    if (mode < 42) begin
      return EdgeSamples[$urandom_range(6)];
    end
    if (mode < 55) begin
      mag = $urandom_range(300);
    end else begin
      case ($urandom_range(2))
        0:       target = regs_shadow.threshold_level;
        1:       target = longint'(regs_shadow.threshold_level) - regs_shadow.knee_width;
        default: target = longint'(regs_shadow.threshold_level) - regs_shadow.knee_width / 2;
      endcase
      target = target + int'($urandom_range(64)) - 32;
      if (target < 0) begin
        target = 0;
      end
      if (regs_shadow.pre_gain_q8 == '0) begin
        mag = $urandom_range(32768);
      end else begin
        mag = (target * 256) / regs_shadow.pre_gain_q8 + int'($urandom_range(2)) - 1;
      end
    end
    neg = 1'($urandom_range(1));
    if (mag < 0) begin
      mag = 0;
    end
    if (mag > 32768) begin
      mag = 32768;
    end
    if (!neg && mag > 32767) begin
      mag = 32767;
    end
    return neg ? 16'(-mag) : 16'(mag);
  endfunction

  // Offer one sample after a random idle gap and hold it until its transfer.
  task automatic send_sample(input logic [SampleW-1:0] smp, input logic lst,
                             input int unsigned idle_pct, input logic known,
                             input pcm_out_t typed);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
    @(negedge clk_i);
    start_i       <= 1'b1;
    sample_in_i   <= smp;
    last_in_i     <= lst;
    next_expected = known ? typed : compress_sample(smp, lst);
    do begin
      @(posedge clk_i);
    end while (busy_o);
  endtask

  // Write one register; bits above its width carry noise that must be dropped.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input longint unsigned value,
                           input int unsigned width);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= 32'(($urandom() << width) | value);
  endtask

  task automatic load_setting(input cfg_t set);
    write_reg(CFG_PRE_GAIN,  set.pre_gain_q8,     GainW);
    write_reg(CFG_THRESHOLD, set.threshold_level, LevelW);
    write_reg(CFG_KNEE,      set.knee_width,      LevelW);
    write_reg(CFG_RATIO,     set.ratio_recip_q16, RatioW);
    write_reg(CFG_COEFF,     set.knee_coeff_q32,  CoeffW);
    write_reg(CFG_VOLUME,    set.volume_percent,  VolW);
    write_reg($urandom_range(1) ? CfgSpareHi : CfgSpareLo, $urandom(), CfgDataW);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Stop offering samples and wait until every pending result has left.
  task automatic settle_pipeline();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (awaited_outputs.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (Latency) @(posedge clk_i);
  endtask

  // Result checking, register shadowing and capture of accepted samples.
  always @(posedge clk_i) begin : monitor
    pcm_out_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (awaited_outputs.size() == 0) begin
          fail_count++;
          if (fail_count <= ReportMax) begin
            $display("unexpected result: sample %0d clipped %b last %b",
                     $signed(sample_out_o), clipped_o, last_out_o);
          end
        end else begin
          want = awaited_outputs.pop_front();
          if (sample_out_o !== want.smp || clipped_o !== want.clip ||
              last_out_o !== want.last) begin
            fail_count++;
            if (fail_count <= ReportMax) begin
              $display("mismatch: got sample %0d clipped %b last %b, want %0d %b %b",
                       $signed(sample_out_o), clipped_o, last_out_o,
                       $signed(want.smp), want.clip, want.last);
            end
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PRE_GAIN:  regs_shadow.pre_gain_q8     = cfg_wdata_i[GainW-1:0];
          CFG_THRESHOLD: regs_shadow.threshold_level = cfg_wdata_i[LevelW-1:0];
          CFG_KNEE:      regs_shadow.knee_width      = cfg_wdata_i[LevelW-1:0];
          CFG_RATIO:     regs_shadow.ratio_recip_q16 = cfg_wdata_i[RatioW-1:0];
          CFG_COEFF:     regs_shadow.knee_coeff_q32  = cfg_wdata_i[CoeffW-1:0];
          CFG_VOLUME:    regs_shadow.volume_percent  = cfg_wdata_i[VolW-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_o) begin
        awaited_outputs.push_back(next_expected);
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

  // Reset, the opening rows, then one phase per register setting, each with one of three idle patterns.
  initial begin : stimulus
    int unsigned phase_pct, burst_pct;
    cfg_t        set;
    pcm_out_t    typed;
    regs_shadow = '{PreGainRst, ThresholdRst, KneeRst, RatioRst, CoeffRst, VolumeRst};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (OpeningRows[i]) begin
      typed = '{OpeningRows[i].exp_smp, OpeningRows[i].exp_clip, OpeningRows[i].last};
      send_sample(OpeningRows[i].smp, OpeningRows[i].last, 0, OpeningRows[i].known, typed);
    end

    for (int p = 0; p < NumPhases; p++) begin
      if (p > 0) begin
        settle_pipeline();
        if (p <= 6) begin
          set = FixedSettings[p-1];
        end else begin
          set.pre_gain_q8     = GainW'($urandom_range(1023));
          set.threshold_level = LevelW'($urandom_range(32767));
          set.knee_width      = LevelW'($urandom_range(32767));
          set.ratio_recip_q16 = RatioW'($urandom_range(131071));
          set.knee_coeff_q32  = $urandom();
          set.volume_percent  = VolW'($urandom_range(127));
        end
        load_setting(set);
      end
      case (p % 3)
        0:       phase_pct = 0;
        1:       phase_pct = 63;
        default: phase_pct = 32;
      endcase
      foreach (EdgeSamples[i]) begin
        send_sample(EdgeSamples[i], 1'($urandom_range(1)), phase_pct, 1'b0, typed);
      end
      // Bursts of sixteen, some of them without any idle cycle.
      burst_pct = phase_pct;
      for (int n = 0; n < RandomPerSet; n++) begin
        if (n % 16 == 0) begin
          burst_pct = ($urandom_range(3) == 0) ? 0 : phase_pct;
        end
        send_sample(pick_sample(), $urandom_range(3) == 0, burst_pct, 1'b0, typed);
      end
    end

    settle_pipeline();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
